@@ hw/rtl/fpk_pkg.sv @@
// Types and constants shared by the FIFO with promote-by-key.
package fpk_pkg;

  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_REMOVE  = 2'd1,
    REQ_PROMOTE = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_SCAN,
    S_APPLY
  } state_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ADD,
    OP_REMOVE,
    OP_MATCH,
    OP_PREFIX,
    OP_PROMOTE
  } cell_op_e;

  localparam int CODE_W = 16;
  localparam int TAG_W  = 8;
  localparam int OCC_W  = 5;

  typedef struct packed {
    cell_op_e op;
    logic     found;
  } cell_ctl_t;

endpackage

@@ hw/rtl/fpk_cell.sv @@
// One slot of the queue chain: entry storage, match flag and prefix candidate.
module fpk_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fpk_pkg::cell_ctl_t        ctl_i,
  input  logic [CW-1:0]             count_i,
  input  logic [fpk_pkg::CODE_W-1:0] wr_code_i,
  input  logic [fpk_pkg::TAG_W-1:0]  wr_tag_i,
  input  logic [fpk_pkg::CODE_W-1:0] key_i,
  input  logic [fpk_pkg::TAG_W-1:0]  head_tag_i,
  input  logic [fpk_pkg::CODE_W-1:0] left_code_i,
  input  logic [fpk_pkg::TAG_W-1:0]  left_tag_i,
  input  logic                      left_hit_i,
  input  logic [fpk_pkg::CODE_W-1:0] right_code_i,
  input  logic [fpk_pkg::TAG_W-1:0]  right_tag_i,
  input  logic                      pfx_hit_i,
  input  logic [fpk_pkg::TAG_W-1:0]  pfx_cand_i,
  output logic [fpk_pkg::CODE_W-1:0] code_o,
  output logic [fpk_pkg::TAG_W-1:0]  tag_o,
  output logic                      hit_o,
  output logic [fpk_pkg::TAG_W-1:0]  cand_o
);

  logic [fpk_pkg::CODE_W-1:0] code_q, code_d;
  logic [fpk_pkg::TAG_W-1:0]  tag_q, tag_d;
  logic [fpk_pkg::TAG_W-1:0]  cand_q, cand_d;
  logic                       hit_q, hit_d;
  logic                       valid;

  assign valid = count_i > CW'(IDX);

  always_comb begin
    code_d = code_q;
    tag_d  = tag_q;
    hit_d  = hit_q;
    cand_d = cand_q;
    case (ctl_i.op)
      fpk_pkg::OP_ADD: begin
        if (count_i == CW'(IDX)) begin
          code_d = wr_code_i;
          tag_d  = wr_tag_i;
        end
      end
      fpk_pkg::OP_REMOVE: begin
        code_d = right_code_i;
        tag_d  = right_tag_i;
      end
      fpk_pkg::OP_MATCH: begin
        hit_d  = valid && (code_q == key_i);
        cand_d = tag_q;
      end
      fpk_pkg::OP_PREFIX: begin
        if (pfx_hit_i) begin
          hit_d  = 1'b1;
          cand_d = pfx_cand_i;
        end
      end
      fpk_pkg::OP_PROMOTE: begin
        if (ctl_i.found) begin
          if (IDX == 0) begin
            code_d = key_i;
            tag_d  = head_tag_i;
          end else if (!hit_q || !left_hit_i) begin
            code_d = left_code_i;
            tag_d  = left_tag_i;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    tag_q  <= tag_d;
    cand_q <= cand_d;
  end

  assign code_o = code_q;
  assign tag_o  = tag_q;
  assign hit_o  = hit_q;
  assign cand_o = cand_q;

endmodule

@@ hw/rtl/fifo_with_promote_by_key.sv @@
// Top level of the FIFO with promote-by-key: control, result register, cell chain.
//
// Input channel (in_valid_i/in_ready_o) takes one request per item: add,
// remove head, or promote the first entry whose code matches to the head.
// Output channel (out_valid_o/out_ready_i) returns one result per request:
// status, removed code and tag (zero unless a remove succeeded) and the
// occupancy after the request.
// Add, remove and the ignored request type are handled in the accept step: the
// result is registered at the accept edge and a new item can be taken in the
// next cycle. Promote runs a compare step, prefix steps along the cell chain
// that locate the first match, and an apply step, so it holds the block from
// accept until its apply step is done.
// Reset empties the queue; slot contents are left as they are.
// While a result waits in the output register and the receiver stalls, no
// new item is taken and a finished promote waits in its apply step.
module fifo_with_promote_by_key #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  req_type_i,
  input  logic [fpk_pkg::CODE_W-1:0]  entry_code_i,
  input  logic [fpk_pkg::TAG_W-1:0]   entry_tag_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [fpk_pkg::CODE_W-1:0]  out_code_o,
  output logic [fpk_pkg::TAG_W-1:0]   out_tag_o,
  output logic [fpk_pkg::OCC_W-1:0]   occupancy_o
);

  localparam int CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int LEVELS = $clog2(QUEUE_DEPTH);
  localparam int LVW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  fpk_pkg::state_e state_q, state_d;
  logic [LVW-1:0]  level_q, level_d;
  logic [CW-1:0]   count_q, count_d;
  logic [fpk_pkg::CODE_W-1:0] key_q;

  logic                       out_valid_q, out_valid_d;
  fpk_pkg::status_e           status_q, status_d;
  logic [fpk_pkg::CODE_W-1:0] out_code_q, out_code_d;
  logic [fpk_pkg::TAG_W-1:0]  out_tag_q, out_tag_d;

  fpk_pkg::cell_ctl_t ctl;
  fpk_pkg::req_e      req;
  logic               accept, out_free, found, is_full, is_empty;

  logic [fpk_pkg::CODE_W-1:0] c_code [QUEUE_DEPTH];
  logic [fpk_pkg::TAG_W-1:0]  c_tag  [QUEUE_DEPTH];
  logic                       c_hit  [QUEUE_DEPTH];
  logic [fpk_pkg::TAG_W-1:0]  c_cand [QUEUE_DEPTH];

  assign req      = fpk_pkg::req_e'(req_type_i);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == fpk_pkg::S_IDLE) && out_free;
  assign accept   = in_valid_i && in_ready_o;
  assign found    = c_hit[QUEUE_DEPTH-1];
  assign is_full  = count_q == CW'(QUEUE_DEPTH);
  assign is_empty = count_q == '0;

  // next state
  always_comb begin
    state_d = state_q;
    level_d = level_q;
    case (state_q)
      fpk_pkg::S_IDLE: begin
        if (accept && req == fpk_pkg::REQ_PROMOTE) begin
          state_d = fpk_pkg::S_MATCH;
        end
      end
      fpk_pkg::S_MATCH: begin
        state_d = fpk_pkg::S_SCAN;
        level_d = '0;
      end
      fpk_pkg::S_SCAN: begin
        if (level_q == LVW'(LEVELS - 1)) begin
          state_d = fpk_pkg::S_APPLY;
        end else begin
          level_d = level_q + 1'b1;
        end
      end
      fpk_pkg::S_APPLY: begin
        if (out_free) begin
          state_d = fpk_pkg::S_IDLE;
        end
      end
      default: state_d = fpk_pkg::S_IDLE;
    endcase
  end

  // outputs: cell commands, count and result register
  always_comb begin
    ctl.op      = fpk_pkg::OP_HOLD;
    ctl.found   = found;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    out_code_d  = out_code_q;
    out_tag_d   = out_tag_q;
    case (state_q)
      fpk_pkg::S_IDLE: begin
        if (accept && req != fpk_pkg::REQ_PROMOTE) begin
          out_valid_d = 1'b1;
          status_d    = fpk_pkg::ST_OK;
          out_code_d  = '0;
          out_tag_d   = '0;
          case (req)
            fpk_pkg::REQ_ADD: begin
              if (is_full) begin
                status_d = fpk_pkg::ST_FULL;
              end else begin
                ctl.op  = fpk_pkg::OP_ADD;
                count_d = count_q + 1'b1;
              end
            end
            fpk_pkg::REQ_REMOVE: begin
              if (is_empty) begin
                status_d = fpk_pkg::ST_EMPTY;
              end else begin
                ctl.op     = fpk_pkg::OP_REMOVE;
                count_d    = count_q - 1'b1;
                out_code_d = c_code[0];
                out_tag_d  = c_tag[0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      fpk_pkg::S_MATCH: ctl.op = fpk_pkg::OP_MATCH;
      fpk_pkg::S_SCAN:  ctl.op = fpk_pkg::OP_PREFIX;
      fpk_pkg::S_APPLY: begin
        if (out_free) begin
          ctl.op      = fpk_pkg::OP_PROMOTE;
          out_valid_d = 1'b1;
          status_d    = found ? fpk_pkg::ST_OK : fpk_pkg::ST_NOT_FOUND;
          out_code_d  = '0;
          out_tag_d   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpk_pkg::S_IDLE;
      level_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= entry_code_i;
    end
    status_q   <= status_d;
    out_code_q <= out_code_d;
    out_tag_q  <= out_tag_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_code_o  = out_code_q;
  assign out_tag_o   = out_tag_q;
  assign occupancy_o = fpk_pkg::OCC_W'(count_q);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [fpk_pkg::CODE_W-1:0] l_code, r_code;
    logic [fpk_pkg::TAG_W-1:0]  l_tag, r_tag;
    logic                       l_hit;
    logic [LEVELS-1:0]          ph;
    logic [fpk_pkg::TAG_W-1:0]  pc [LEVELS];
    logic                       pfx_hit;
    logic [fpk_pkg::TAG_W-1:0]  pfx_cand;

    if (i == 0) begin : g_first
      assign l_code = '0;
      assign l_tag  = '0;
      assign l_hit  = 1'b0;
    end else begin : g_mid
      assign l_code = c_code[i-1];
      assign l_tag  = c_tag[i-1];
      assign l_hit  = c_hit[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign r_code = '0;
      assign r_tag  = '0;
    end else begin : g_inner
      assign r_code = c_code[i+1];
      assign r_tag  = c_tag[i+1];
    end

    for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
      if (i >= (1 << k)) begin : g_tap
        assign ph[k] = c_hit[i-(1<<k)];
        assign pc[k] = c_cand[i-(1<<k)];
      end else begin : g_none
        assign ph[k] = 1'b0;
        assign pc[k] = '0;
      end
    end

    always_comb begin
      pfx_hit  = 1'b0;
      pfx_cand = '0;
      for (int k = 0; k < LEVELS; k++) begin
        if (level_q == LVW'(k)) begin
          pfx_hit  = ph[k];
          pfx_cand = pc[k];
        end
      end
    end

    fpk_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .count_i      (count_q),
      .wr_code_i    (entry_code_i),
      .wr_tag_i     (entry_tag_i),
      .key_i        (key_q),
      .head_tag_i   (c_cand[QUEUE_DEPTH-1]),
      .left_code_i  (l_code),
      .left_tag_i   (l_tag),
      .left_hit_i   (l_hit),
      .right_code_i (r_code),
      .right_tag_i  (r_tag),
      .pfx_hit_i    (pfx_hit),
      .pfx_cand_i   (pfx_cand),
      .code_o       (c_code[i]),
      .tag_o        (c_tag[i]),
      .hit_o        (c_hit[i]),
      .cand_o       (c_cand[i])
    );
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_full_add_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req == fpk_pkg::REQ_ADD && is_full) |=> count_q == $past(count_q))
    else $error("refused add changed the count");

  a_promote_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req == fpk_pkg::REQ_PROMOTE) |=> state_q == fpk_pkg::S_MATCH)
    else $error("promote did not start a match");

  a_promote_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpk_pkg::S_SCAN || state_q == fpk_pkg::S_APPLY) |=>
      count_q == $past(count_q))
    else $error("count changed during promote");

endmodule

@@ tb/sv/fifo_with_promote_by_key_tb.sv @@
// Testbench for the FIFO with promote-by-key: directed table, random traffic, scoreboard.
module fifo_with_promote_by_key_tb;

  localparam int DEPTH       = 16;
  localparam int RAND_ITEMS  = 800;
  localparam int HOLD_CYCLES = 80;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int BURST_ITEMS = 30;
  localparam int CODE_W      = fpk_pkg::CODE_W;
  localparam int TAG_W       = fpk_pkg::TAG_W;
  localparam int OCC_W       = fpk_pkg::OCC_W;

  typedef struct packed {
    fpk_pkg::status_e   status;
    logic [CODE_W-1:0]  code;
    logic [TAG_W-1:0]   tag;
    logic [OCC_W-1:0]   occ;
  } result_t;

  typedef struct {
    fpk_pkg::req_e      req;
    logic [CODE_W-1:0]  code;
    logic [TAG_W-1:0]   tag;
    bit                 pinned;
    result_t            res;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic [1:0]         req_type_i   = fpk_pkg::REQ_NONE;
  logic [CODE_W-1:0]  entry_code_i = '0;
  logic [TAG_W-1:0]   entry_tag_i  = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic [1:0]         status_o;
  logic [CODE_W-1:0]  out_code_o;
  logic [TAG_W-1:0]   out_tag_o;
  logic [OCC_W-1:0]   occupancy_o;

  // fixed expectation travels alongside the payload of a directed item
  logic               pin_v = 1'b0;
  result_t            pin_r = '0;

  logic [CODE_W-1:0]  slot_code [DEPTH];
  logic [TAG_W-1:0]   slot_tag  [DEPTH];
  int unsigned        slot_cnt = 0;

  result_t            pending_results[$];
  stim_row_t          dir_tab[$];
  int unsigned        errors = 0;
  int unsigned        idle_cnt = 0;
  int unsigned        burst_left = 0;
  bit                 hold_off_req = 1'b0;

  fifo_with_promote_by_key #(.QUEUE_DEPTH(DEPTH)) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .entry_code_i (entry_code_i),
    .entry_tag_i  (entry_tag_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .out_code_o   (out_code_o),
    .out_tag_o    (out_tag_o),
    .occupancy_o  (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic result_t apply_request(fpk_pkg::req_e r, logic [CODE_W-1:0] c,
                                            logic [TAG_W-1:0] t);
    result_t           res;
    int                pos;
    logic [CODE_W-1:0] mc;
    logic [TAG_W-1:0]  mt;
    res.status = fpk_pkg::ST_OK;
    res.code   = '0;
    res.tag    = '0;
    pos        = -1;
    case (r)
      fpk_pkg::REQ_ADD: begin
        if (slot_cnt >= DEPTH) begin
          res.status = fpk_pkg::ST_FULL;
        end else begin
          slot_code[slot_cnt] = c;
          slot_tag[slot_cnt]  = t;
          slot_cnt++;
        end
      end
      fpk_pkg::REQ_REMOVE: begin
        if (slot_cnt == 0) begin
          res.status = fpk_pkg::ST_EMPTY;
        end else begin
          res.code = slot_code[0];
          res.tag  = slot_tag[0];
          for (int i = 1; i < slot_cnt; i++) begin
            slot_code[i-1] = slot_code[i];
            slot_tag[i-1]  = slot_tag[i];
          end
          slot_cnt--;
        end
      end
      fpk_pkg::REQ_PROMOTE: begin
        for (int i = 0; i < slot_cnt; i++) begin
          if (pos < 0 && slot_code[i] == c) pos = i;
        end
        if (pos < 0) begin
          res.status = fpk_pkg::ST_NOT_FOUND;
        end else begin
          mc = slot_code[pos];
          mt = slot_tag[pos];
          for (int i = pos; i > 0; i--) begin
            slot_code[i] = slot_code[i-1];
            slot_tag[i]  = slot_tag[i-1];
          end
          slot_code[0] = mc;
          slot_tag[0]  = mt;
        end
      end
      default: ;
    endcase
    res.occ = OCC_W'(slot_cnt);
    return res;
  endfunction

  task automatic report(string msg);
    if (errors < 30) $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk_i) begin
    result_t want;
    result_t pred;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report($sformatf("unexpected result status %0d code %h", status_o, out_code_o));
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status)
            report($sformatf("status %0d, expected %0d", status_o, want.status));
          if (out_code_o !== want.code)
            report($sformatf("out_code %h, expected %h", out_code_o, want.code));
          if (out_tag_o !== want.tag)
            report($sformatf("out_tag %h, expected %h", out_tag_o, want.tag));
          if (occupancy_o !== want.occ)
            report($sformatf("occupancy %0d, expected %0d", occupancy_o, want.occ));
        end
      end
      if (in_valid_i && in_ready_o) begin
        pred = apply_request(fpk_pkg::req_e'(req_type_i), entry_code_i, entry_tag_i);
        pending_results.push_back(pin_v ? pin_r : pred);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: rotating ready pattern, plus a long hold-off on request
  initial begin
    int unsigned cyc;
    bit          rdy;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        case ((cyc / 50) % 4)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(1));
          2:       rdy = (cyc % 4 == 0);
          default: rdy = ($urandom_range(6) != 0);
        endcase
        out_ready_i <= rdy;
        cyc++;
      end
    end
  end

  task automatic send_item(fpk_pkg::req_e r, logic [CODE_W-1:0] c, logic [TAG_W-1:0] t,
                           bit pv, result_t pr);
    in_valid_i   <= 1'b1;
    req_type_i   <= r;
    entry_code_i <= c;
    entry_tag_i  <= t;
    pin_v        <= pv;
    pin_r        <= pr;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic dir_row(fpk_pkg::req_e r, logic [CODE_W-1:0] c, logic [TAG_W-1:0] t,
                         bit pin, fpk_pkg::status_e s, logic [CODE_W-1:0] ec,
                         logic [TAG_W-1:0] et, logic [OCC_W-1:0] eo);
    stim_row_t row;
    row.req        = r;
    row.code       = c;
    row.tag        = t;
    row.pinned     = pin;
    row.res.status = s;
    row.res.code   = ec;
    row.res.tag    = et;
    row.res.occ    = eo;
    dir_tab.push_back(row);
  endtask

  task automatic pick_request(int unsigned add_pct, output fpk_pkg::req_e r,
                              output logic [CODE_W-1:0] c, output logic [TAG_W-1:0] t);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) r = fpk_pkg::REQ_NONE;
    else if (roll < 3 + add_pct) r = fpk_pkg::REQ_ADD;
    else if (roll < 3 + add_pct + (97 - add_pct) / 2) r = fpk_pkg::REQ_REMOVE;
    else r = fpk_pkg::REQ_PROMOTE;
    roll = $urandom_range(99);
    if (roll < 40 && slot_cnt > 0) c = slot_code[$urandom_range(slot_cnt - 1)];
    else if (roll < 70) c = CODE_W'($urandom_range(7));
    else if (roll < 75) c = '1;
    else c = CODE_W'($urandom);
    t = TAG_W'($urandom);
  endtask

  initial begin
    fpk_pkg::req_e     r;
    logic [CODE_W-1:0] c;
    logic [TAG_W-1:0]  t;
    int unsigned       add_pct;
    result_t           none;
    none = '0;
    dir_row(fpk_pkg::REQ_REMOVE,  16'h0000, 8'h00, 1'b1, fpk_pkg::ST_EMPTY, '0, '0, 5'd0);
    dir_row(fpk_pkg::REQ_PROMOTE, 16'hFFFF, 8'hFF, 1'b1, fpk_pkg::ST_NOT_FOUND, '0, '0, 5'd0);
    dir_row(fpk_pkg::REQ_NONE,    16'hFFFF, 8'hFF, 1'b1, fpk_pkg::ST_OK, '0, '0, 5'd0);
    dir_row(fpk_pkg::REQ_ADD,     16'h0000, 8'h00, 1'b1, fpk_pkg::ST_OK, '0, '0, 5'd1);
    dir_row(fpk_pkg::REQ_ADD,     16'hFFFF, 8'hFF, 1'b1, fpk_pkg::ST_OK, '0, '0, 5'd2);
    dir_row(fpk_pkg::REQ_ADD,     16'h1234, 8'hA5, 1'b1, fpk_pkg::ST_OK, '0, '0, 5'd3);
    dir_row(fpk_pkg::REQ_PROMOTE, 16'hFFFF, 8'h00, 1'b0, fpk_pkg::ST_OK, '0, '0, 5'd0);
    // already at the head
    dir_row(fpk_pkg::REQ_PROMOTE, 16'hFFFF, 8'h00, 1'b0, fpk_pkg::ST_OK, '0, '0, 5'd0);
    dir_row(fpk_pkg::REQ_PROMOTE, 16'hBEEF, 8'h00, 1'b1, fpk_pkg::ST_NOT_FOUND, '0, '0, 5'd3);
    for (int k = 0; k < 13; k++) begin
      if (k == 4) c = 16'h1234;
      else if (k == 12) c = 16'hC0DE;
      else c = CODE_W'(16'h0100 + k);
      dir_row(fpk_pkg::REQ_ADD, c, TAG_W'(k * 19), 1'b0, fpk_pkg::ST_OK, '0, '0, 5'd0);
    end
    dir_row(fpk_pkg::REQ_ADD,     16'h5555, 8'h55, 1'b1, fpk_pkg::ST_FULL, '0, '0, 5'd16);
    // tail entry, then a duplicated code where the first match wins
    dir_row(fpk_pkg::REQ_PROMOTE, 16'hC0DE, 8'h00, 1'b0, fpk_pkg::ST_OK, '0, '0, 5'd0);
    dir_row(fpk_pkg::REQ_PROMOTE, 16'h1234, 8'h00, 1'b0, fpk_pkg::ST_OK, '0, '0, 5'd0);
    dir_row(fpk_pkg::REQ_REMOVE,  16'h0000, 8'h00, 1'b0, fpk_pkg::ST_OK, '0, '0, 5'd0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[k]) begin
      send_item(dir_tab[k].req, dir_tab[k].code, dir_tab[k].tag,
                dir_tab[k].pinned, dir_tab[k].res);
      pace();
    end

    add_pct = 50;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       add_pct = 75;
          1:       add_pct = 25;
          default: add_pct = 50;
        endcase
      end
      if (n == 200) begin
        hold_off_req = 1'b1;
        for (int b = 0; b < BURST_ITEMS; b++) begin
          pick_request(add_pct, r, c, t);
          send_item(r, c, t, 1'b0, none);
        end
      end
      if (n == 400) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      pick_request(add_pct, r, c, t);
      send_item(r, c, t, 1'b0, none);
      pace();
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/fpk_pkg.sv
hw/rtl/fpk_cell.sv
hw/rtl/fifo_with_promote_by_key.sv
tb/sv/fifo_with_promote_by_key_tb.sv
